>>> hw/rtl/lsmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsmb_pkg
// Shared types, constants and the arctangent table for the scan merge block.
// ----------------------------------------------------------------------------
package lsmb_pkg;

    // Default number of angular bins
    localparam int BINS_DEFAULT = 360;

    // Field widths
    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int INDEX_W  = 12;
    localparam int OFFS_W   = 16;
    localparam int QUERY_W  = 9;
    localparam int THRESH_W = 16;
    localparam int COUNT_W  = 16;

    // CORDIC datapath widths: x/y in Q16 mm, z in units of 2pi/2^24
    localparam int XW        = 37;
    localparam int ZW        = 27;
    localparam int TW        = 41;
    localparam int STEPS     = 16;
    localparam int STEP_W    = 4;
    localparam int PROD_W    = 52;
    localparam int BIN_SEL_W = 13;
    localparam int ENTRY_W   = 17;

    localparam logic [15:0]        INV_GAIN     = 16'd39797;
    localparam logic [RANGE_W-1:0] NO_RETURN    = 16'hFFFF;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1500;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [ENTRY_W-1:0] EMPTY_MARK   = 17'h10000;

    localparam logic signed [ZW-1:0] HALF_TURN    = 27'sd8388608;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 27'sd4194304;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_END    = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Classified word passed from front to back
    typedef struct packed {
        kind_t                     kind;
        logic [RANGE_W-1:0]        range_mm;
        logic [ANGLE_W-1:0]        theta;
        logic signed [OFFS_W-1:0]  offset_x;
        logic signed [OFFS_W-1:0]  offset_y;
        logic [QUERY_W-1:0]        query_bin;
    } cmd_t;

    // Back end sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_ROT,
        S_OFFSET,
        S_VINIT,
        S_VEC,
        S_DIST,
        S_BIN,
        S_LOOK,
        S_UPDATE
    } state_t;

    // Arctangent of 2^-i in units of 2pi/2^24
    function automatic logic [ZW-1:0] atan_lookup(input logic [STEP_W-1:0] i);
        logic [ZW-1:0] v;
        unique case (i)
            4'd0:  v = 27'd2097152;
            4'd1:  v = 27'd1238021;
            4'd2:  v = 27'd654136;
            4'd3:  v = 27'd332050;
            4'd4:  v = 27'd166669;
            4'd5:  v = 27'd83416;
            4'd6:  v = 27'd41718;
            4'd7:  v = 27'd20860;
            4'd8:  v = 27'd10430;
            4'd9:  v = 27'd5215;
            4'd10: v = 27'd2608;
            4'd11: v = 27'd1304;
            4'd12: v = 27'd652;
            4'd13: v = 27'd326;
            4'd14: v = 27'd163;
            default: v = 27'd81;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/lsmb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsmb_front
// Accepts input words, forms the total beam angle and hands classified
// words to the queue. Unknown kinds are dropped here.
// ----------------------------------------------------------------------------
module lsmb_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [1:0]                         kind,
    input  logic [lsmb_pkg::RANGE_W-1:0]       range_mm,
    input  logic [lsmb_pkg::ANGLE_W-1:0]       start_angle,
    input  logic [lsmb_pkg::ANGLE_W-1:0]       step_angle,
    input  logic [lsmb_pkg::INDEX_W-1:0]       sample_index,
    input  logic [lsmb_pkg::ANGLE_W-1:0]       sensor_yaw,
    input  logic signed [lsmb_pkg::OFFS_W-1:0] offset_x,
    input  logic signed [lsmb_pkg::OFFS_W-1:0] offset_y,
    input  logic [lsmb_pkg::QUERY_W-1:0]       query_bin,
    input  logic                               q_full,
    output logic                               stall,
    output logic                               q_push,
    output lsmb_pkg::cmd_t                     q_data
);
    import lsmb_pkg::*;

    logic  valid_reg;
    cmd_t  cmd_reg;
    cmd_t  cmd_next;
    logic  leave;

    // Form the beam angle modulo a full turn
    always_comb
    begin
        cmd_next.kind      = kind_t'(kind);
        cmd_next.range_mm  = range_mm;
        cmd_next.theta     = ANGLE_W'(start_angle
                             + ANGLE_W'(sample_index * step_angle) + sensor_yaw);
        cmd_next.offset_x  = offset_x;
        cmd_next.offset_y  = offset_y;
        cmd_next.query_bin = query_bin;
    end

    assign leave  = valid_reg && !q_full;
    assign stall  = valid_reg && q_full;
    assign q_push = leave && (cmd_reg.kind != KIND_NONE);
    assign q_data = cmd_reg;

    // Hold the word until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (leave)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

>>> hw/rtl/lsmb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsmb_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module lsmb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lsmb_pkg::cmd_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output lsmb_pkg::cmd_t head
);
    import lsmb_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/lsmb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsmb_back
// Runs the CORDIC rotate and vector passes on one shared unit, bins the
// point and keeps per-bin minima in a memory; answers reads and clears.
// ----------------------------------------------------------------------------
module lsmb_back #(
    parameter int BINS = lsmb_pkg::BINS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lsmb_pkg::THRESH_W-1:0]     cfg_data,
    input  logic                              q_empty,
    input  lsmb_pkg::cmd_t                    head,
    output logic                              q_pop,
    output logic                              clearing,
    output logic                              result_valid,
    output logic [lsmb_pkg::RANGE_W-1:0]      bin_range,
    output logic                              bin_empty
);
    import lsmb_pkg::*;

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam logic [BIN_SEL_W-1:0] BINS_SEL  = BIN_SEL_W'(BINS);
    localparam logic [AW-1:0]        LAST_ADDR = AW'(BINS - 1);

    // Bin memory
    logic [ENTRY_W-1:0] mem [BINS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    state_t state_reg, state_next;
    logic [THRESH_W-1:0]        thresh_reg;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [AW-1:0]              ctr_reg, ctr_next;
    logic [STEP_W-1:0]          it_reg, it_next;
    logic signed [XW-1:0]       x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]       z_reg, z_next;
    logic signed [OFFS_W-1:0]   offx_reg, offx_next, offy_reg, offy_next;
    logic                       oor_reg, oor_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [RANGE_W-1:0]         dist_reg, dist_next;
    logic signed [TW-1:0]       t_reg, t_next;
    logic                       res_valid_reg, res_valid_next;
    logic [RANGE_W-1:0]         res_range_reg, res_range_next;
    logic                       res_empty_reg, res_empty_next;

    // Shared CORDIC step signals
    logic                       sigma;
    logic signed [XW-1:0]       xs, ys;
    logic [ZW-1:0]              atan_v;
    logic signed [ZW-1:0]       zinit;
    logic signed [XW-1:0]       xinit;
    logic [BIN_SEL_W-1:0]       q_wide;
    logic signed [ZW-1:0]       u_val;
    logic [PROD_W-1:0]          rounded;
    logic [TW-25:0]             bin_hi;

    assign clearing     = (state_reg == S_CLEAR);
    assign result_valid = res_valid_reg;
    assign bin_range    = res_range_reg;
    assign bin_empty    = res_empty_reg;

    assign xs     = y_reg >>> it_reg;
    assign ys     = x_reg >>> it_reg;
    assign atan_v = atan_lookup(it_reg);
    assign sigma  = (state_reg == S_ROT) ? !z_reg[ZW-1] : y_reg[XW-1];
    assign zinit  = ZW'($signed({head.theta, 8'h00}));
    assign xinit  = $signed({5'd0, 32'(head.range_mm * INV_GAIN)});
    assign q_wide = BIN_SEL_W'(head.query_bin);
    assign u_val  = z_reg + HALF_TURN;
    assign rounded = prod_reg + PROD_W'(64'h80000000);
    assign bin_hi = t_reg[TW-1:24];

    // Memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ctr_next       = ctr_reg;
        it_next        = it_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        offx_next      = offx_reg;
        offy_next      = offy_reg;
        oor_next       = oor_reg;
        prod_next      = prod_reg;
        dist_next      = dist_reg;
        t_next         = t_reg;
        res_valid_next = 1'b0;
        res_range_next = res_range_reg;
        res_empty_next = res_empty_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = ctr_reg;
        wr_data        = EMPTY_MARK;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep every bin to empty
                wr_en = 1'b1;
                ctr_next = ctr_reg + AW'(1);
                if (ctr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    offx_next = head.offset_x;
                    offy_next = head.offset_y;
                    priority case (head.kind)
                        KIND_READ:
                        begin
                            oor_next = (q_wide >= BINS_SEL);
                            rd_en = 1'b1;
                            rd_addr = q_wide[AW-1:0];
                            state_next = S_READ;
                        end
                        KIND_END:
                        begin
                            if (count_reg >= thresh_reg)
                            begin
                                count_next = '0;
                                ctr_next = '0;
                                state_next = S_CLEAR;
                            end
                        end
                        KIND_SAMPLE:
                        begin
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                            if (head.range_mm != NO_RETURN)
                            begin
                                // Fold into the right half plane before rotating
                                it_next = '0;
                                y_next = '0;
                                if (zinit > QUARTER_TURN)
                                begin
                                    x_next = -xinit;
                                    z_next = zinit - HALF_TURN;
                                end
                                else if (zinit < -QUARTER_TURN)
                                begin
                                    x_next = -xinit;
                                    z_next = zinit + HALF_TURN;
                                end
                                else
                                begin
                                    x_next = xinit;
                                    z_next = zinit;
                                end
                                state_next = S_ROT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_valid_next = 1'b1;
                if (oor_reg || rd_data_reg[ENTRY_W-1])
                begin
                    res_range_next = '0;
                    res_empty_next = 1'b1;
                end
                else
                begin
                    res_range_next = rd_data_reg[RANGE_W-1:0];
                    res_empty_next = 1'b0;
                end
                state_next = S_IDLE;
            end
            S_ROT, S_VEC:
            begin
                // One micro-rotation per cycle
                if (sigma)
                begin
                    x_next = x_reg - xs;
                    y_next = y_reg + ys;
                    z_next = z_reg - $signed(atan_v);
                end
                else
                begin
                    x_next = x_reg + xs;
                    y_next = y_reg - ys;
                    z_next = z_reg + $signed(atan_v);
                end
                it_next = it_reg + STEP_W'(1);
                if (it_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = (state_reg == S_ROT) ? S_OFFSET : S_DIST;
                end
            end
            S_OFFSET:
            begin
                // Add the sensor offset in Q16, sign extended
                x_next = x_reg + XW'($signed({offx_reg, 16'h0000}));
                y_next = y_reg + XW'($signed({offy_reg, 16'h0000}));
                state_next = S_VINIT;
            end
            S_VINIT:
            begin
                // Flip left half plane points by a half turn
                it_next = '0;
                if (x_reg[XW-1])
                begin
                    z_next = y_reg[XW-1] ? -HALF_TURN : HALF_TURN;
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
                else
                begin
                    z_next = '0;
                end
                state_next = S_VEC;
            end
            S_DIST:
            begin
                prod_next = PROD_W'(x_reg[XW-2:0] * INV_GAIN);
                state_next = S_BIN;
            end
            S_BIN:
            begin
                dist_next = (rounded[PROD_W-1:48] != '0) ? COUNT_MAX : rounded[47:32];
                t_next = TW'(u_val * $signed({1'b0, BINS_SEL})) + TW'(HALF_TURN);
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                // Drop points below the first or beyond the last bin, or on an edge
                if (t_reg[TW-1] || (t_reg[23:0] == '0)
                    || (bin_hi >= (TW-24)'(BINS_SEL)))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = bin_hi[AW-1:0];
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                wr_addr = bin_hi[AW-1:0];
                wr_data = ENTRY_W'(dist_reg);
                wr_en = (ENTRY_W'(dist_reg) < rd_data_reg);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ctr_reg       <= '0;
            count_reg     <= '0;
            thresh_reg    <= THRESH_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write)
            begin
                thresh_reg <= cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        it_reg        <= it_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        offx_reg      <= offx_next;
        offy_reg      <= offy_next;
        oor_reg       <= oor_next;
        prod_reg      <= prod_next;
        dist_reg      <= dist_next;
        t_reg         <= t_next;
        res_range_reg <= res_range_next;
        res_empty_reg <= res_empty_next;
    end

endmodule

>>> hw/rtl/lidar_scan_merge_binning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_merge_binning
// A sample runs two 16-step CORDIC passes on one shared unit in the back end,
// then the bin lookup and update; a read is answered from the bin memory.
// The back end works on one sample at a time; a two-word queue lets the
// front accept while the back works.
// Reset: a sweep clears all bins after reset (busy held high), and again
// after each end of scan that clears. Results cannot be stalled.
// ----------------------------------------------------------------------------
module lidar_scan_merge_binning #(
    parameter int BINS = lsmb_pkg::BINS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         kind,
    input  logic [lsmb_pkg::RANGE_W-1:0]       range_mm,
    input  logic [lsmb_pkg::ANGLE_W-1:0]       start_angle,
    input  logic [lsmb_pkg::ANGLE_W-1:0]       step_angle,
    input  logic [lsmb_pkg::INDEX_W-1:0]       sample_index,
    input  logic [lsmb_pkg::ANGLE_W-1:0]       sensor_yaw,
    input  logic signed [lsmb_pkg::OFFS_W-1:0] offset_x,
    input  logic signed [lsmb_pkg::OFFS_W-1:0] offset_y,
    input  logic [lsmb_pkg::QUERY_W-1:0]       query_bin,
    input  logic                               cfg_write,
    input  logic [lsmb_pkg::THRESH_W-1:0]      cfg_data,
    output logic                               result_valid,
    output logic [lsmb_pkg::RANGE_W-1:0]       bin_range,
    output logic                               bin_empty
);
    import lsmb_pkg::*;

    logic accept;
    logic stall;
    logic clearing;
    logic q_push, q_pop, q_full, q_empty;
    cmd_t q_data, q_head;

    // Accept a word only when the front is free and no sweep runs
    assign busy   = stall || clearing;
    assign accept = start && !busy;

    lsmb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .kind         (kind),
        .range_mm     (range_mm),
        .start_angle  (start_angle),
        .step_angle   (step_angle),
        .sample_index (sample_index),
        .sensor_yaw   (sensor_yaw),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .query_bin    (query_bin),
        .q_full       (q_full),
        .stall        (stall),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    lsmb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    lsmb_back #(
        .BINS (BINS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .q_empty      (q_empty),
        .head         (q_head),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .bin_range    (bin_range),
        .bin_empty    (bin_empty)
    );

endmodule
